>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a named clock, disabled while the named reset is high.
`define WSP_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same check on the block's usual clock and reset.
`define WSP_ASSERT(label, prop, msg) \
   `WSP_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

>>> rtl/wsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wsp_pkg;

   // wheels handled by the state arrays
   localparam int WHEEL_COUNT = 2;

   // fixed point
   localparam int FRAC_BITS = 20;
   localparam int SUM_LIMIT = 240;
   localparam int DEAD_ZONE = 5;
   localparam int DUTY_MAX  = 255;

   // field widths
   localparam int COUNT_W = 32;
   localparam int SPEED_W = 16;
   localparam int ERR_W   = 17;
   localparam int PERR_W  = 18;
   localparam int INTEG_W = 29;
   localparam int P_W     = 33;
   localparam int INC_W   = 34;
   localparam int SUM_W   = 45;

   // shared multiplier
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 25;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P          = 3'd0,
      CSR_GAIN_I          = 3'd1,
      CSR_GAIN_D          = 3'd2,
      CSR_SPEED_PER_COUNT = 3'd3,
      CSR_TICK_PERIOD     = 3'd4,
      CSR_TICK_RATE       = 3'd5,
      CSR_MIN_START_DUTY  = 3'd6,
      CSR_INTEGRAL_LIMIT  = 3'd7
   } csr_index_type;

   // reset values of the registers
   localparam logic [15:0] GAIN_P_RST          = 16'd7680;
   localparam logic [15:0] GAIN_I_RST          = 16'd256;
   localparam logic [15:0] GAIN_D_RST          = 16'd13;
   localparam logic [23:0] SPEED_PER_COUNT_RST = 24'd514718;
   localparam logic [15:0] TICK_PERIOD_RST     = 16'd1311;
   localparam logic [9:0]  TICK_RATE_RST       = 10'd50;
   localparam logic [7:0]  MIN_START_DUTY_RST  = 8'd46;
   localparam logic [7:0]  INTEGRAL_LIMIT_RST  = 8'd60;

   // bridge drive codes
   typedef enum logic [1:0] {
      DRIVE_OFF     = 2'd0,
      DRIVE_FORWARD = 2'd1,
      DRIVE_REVERSE = 2'd2
   } drive_type;

endpackage

`default_nettype wire

>>> rtl/wsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

// tick request channel
interface wsp_req_if;
   import wsp_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       wheel;
   logic signed [COUNT_W-1:0]  encoder_count;
   logic signed [SPEED_W-1:0]  target_speed;
   logic                       clear_integral;

   modport source (output valid, output wheel, output encoder_count,
                   output target_speed, output clear_integral, input ready);
   modport sink   (input valid, input wheel, input encoder_count,
                   input target_speed, input clear_integral, output ready);
endinterface

// drive result channel
interface wsp_rsp_if;
   import wsp_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       wheel_out;
   logic [1:0]                 drive;
   logic [7:0]                 duty;
   logic signed [SPEED_W-1:0]  measured_speed;

   modport source (output valid, output wheel_out, output drive, output duty,
                   output measured_speed, input ready);
   modport sink   (input valid, input wheel_out, input drive, input duty,
                   input measured_speed, output ready);
endinterface

`default_nettype wire

>>> rtl/wsp_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared signed multiplier, product registered.
module wsp_mul (
   input  wire logic                                 clock,
   input  wire logic signed [wsp_pkg::MUL_A_W-1:0]  mul_a,
   input  wire logic signed [wsp_pkg::MUL_B_W-1:0]  mul_b,
   output logic signed [wsp_pkg::MUL_P_W-1:0]       product
);
   import wsp_pkg::*;

   logic signed [MUL_P_W-1:0] prod_ff;
   logic signed [MUL_P_W-1:0] prod_in;

   always_comb begin
      prod_in = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

`default_nettype wire

>>> rtl/wheel_speed_pid_pwm.sv
`timescale 1ns / 1ps
`default_nettype none

// Wheel speed PID controller with PWM drive output. Each request item carries
// one control tick for one wheel: the encoder position, the target speed and
// an integral clear flag. The block turns the count change since that wheel's
// last tick into a measured speed, runs PID with a clamped, conditionally
// growing integral term, and returns one result item with bridge direction,
// duty and measured speed. All six products go through one registered
// 34x25 multiplier under a sequencer that steps through the SPD, ERR, P,
// I1, I2, D1, D2, SUM and OUT states, and OUT waits until the result
// register is free. The request side is not ready while an item is being
// worked on; a finished result waits in its own register, so the next
// request can be accepted while it is held. The user must write gains and
// scaling through the csr port while the block is idle; this is not enforced.
module wheel_speed_pid_pwm (
   input  wire logic                              clock,
   input  wire logic                              reset,
   wsp_req_if.sink                                req_if,
   wsp_rsp_if.source                              rsp_if,
   input  wire logic                              csr_we,
   input  wire logic [wsp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [wsp_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import wsp_pkg::*;

   `include "assert_macros.svh"

   typedef enum logic [9:0] {
      ST_IDLE = 10'b00_0000_0001,
      ST_SPD  = 10'b00_0000_0010,
      ST_ERR  = 10'b00_0000_0100,
      ST_P    = 10'b00_0000_1000,
      ST_I1   = 10'b00_0001_0000,
      ST_I2   = 10'b00_0010_0000,
      ST_D1   = 10'b00_0100_0000,
      ST_D2   = 10'b00_1000_0000,
      ST_SUM  = 10'b01_0000_0000,
      ST_OUT  = 10'b10_0000_0000
   } state_type;

   localparam logic signed [INC_W-1:0] SUM_LIM_Q = INC_W'(SUM_LIMIT * (2 ** FRAC_BITS));

   // configuration registers
   logic [15:0] gain_p_ff, gain_i_ff, gain_d_ff, tick_period_ff;
   logic [23:0] speed_per_count_ff;
   logic [9:0]  tick_rate_ff;
   logic [7:0]  min_start_duty_ff, integral_limit_ff;

   // per-wheel state
   logic signed [INTEG_W-1:0] integ_ff [WHEEL_COUNT];
   logic signed [INTEG_W-1:0] integ_in [WHEEL_COUNT];
   logic signed [PERR_W-1:0]  perr_ff  [WHEEL_COUNT];
   logic signed [PERR_W-1:0]  perr_in  [WHEEL_COUNT];
   logic [COUNT_W-1:0]        last_ff  [WHEEL_COUNT];
   logic [COUNT_W-1:0]        last_in  [WHEEL_COUNT];

   // sequencer and working registers
   state_type                 st_ff, st_in;
   logic                      wheel_ff, wheel_in;
   logic                      oor_ff, oor_in;
   logic                      grow_ff, grow_in;
   logic signed [SPEED_W-1:0] target_ff, target_in;
   logic signed [SPEED_W-1:0] speed_ff, speed_in;
   logic signed [COUNT_W-1:0] delta_ff, delta_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [P_W-1:0]     p_ff, p_in;
   logic signed [INC_W-1:0]   inc_ff, inc_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_wheel_ff, rsp_wheel_in;
   drive_type                 rsp_drive_ff, rsp_drive_in;
   logic [7:0]                rsp_duty_ff, rsp_duty_in;
   logic signed [SPEED_W-1:0] rsp_speed_ff, rsp_speed_in;

   // datapath
   logic                      req_fire, rsp_free, in_range;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] product;
   logic signed [INTEG_W-1:0] cur_integ;
   logic signed [PERR_W-1:0]  cur_perr;
   logic signed [56:0]        spd_rnd;
   logic signed [40:0]        spd_sh;
   logic signed [SPEED_W-1:0] spd_sat;
   logic signed [PERR_W-1:0]  diff;
   logic signed [49:0]        inc_rnd;
   logic signed [INC_W-1:0]   psum;
   logic                      sign_ok;
   logic signed [INC_W:0]     ival, ilim, integ_chk;
   logic signed [INTEG_W-1:0] integ_new;
   logic [SUM_W-1:0]          abs_sum;
   logic [24:0]               mag, mag_adj;

   // shared multiplier
   wsp_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff          <= GAIN_P_RST;
         gain_i_ff          <= GAIN_I_RST;
         gain_d_ff          <= GAIN_D_RST;
         speed_per_count_ff <= SPEED_PER_COUNT_RST;
         tick_period_ff     <= TICK_PERIOD_RST;
         tick_rate_ff       <= TICK_RATE_RST;
         min_start_duty_ff  <= MIN_START_DUTY_RST;
         integral_limit_ff  <= INTEGRAL_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_GAIN_P:          gain_p_ff          <= csr_wdata[15:0];
            CSR_GAIN_I:          gain_i_ff          <= csr_wdata[15:0];
            CSR_GAIN_D:          gain_d_ff          <= csr_wdata[15:0];
            CSR_SPEED_PER_COUNT: speed_per_count_ff <= csr_wdata[23:0];
            CSR_TICK_PERIOD:     tick_period_ff     <= csr_wdata[15:0];
            CSR_TICK_RATE:       tick_rate_ff       <= csr_wdata[9:0];
            CSR_MIN_START_DUTY:  min_start_duty_ff  <= csr_wdata[7:0];
            CSR_INTEGRAL_LIMIT:  integral_limit_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // handshakes
   assign req_if.ready          = (st_ff == ST_IDLE);
   assign req_fire              = req_if.valid && req_if.ready;
   assign rsp_free              = !rsp_valid_ff || rsp_if.ready;
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.wheel_out      = rsp_wheel_ff;
   assign rsp_if.drive          = rsp_drive_ff;
   assign rsp_if.duty           = rsp_duty_ff;
   assign rsp_if.measured_speed = rsp_speed_ff;

   assign in_range  = int'(req_if.wheel) < WHEEL_COUNT;
   assign cur_integ = integ_ff[wheel_ff];
   assign cur_perr  = perr_ff[wheel_ff];

   // multiplier operands per step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (st_ff)
         ST_SPD: begin
            mul_a = MUL_A_W'(delta_ff);
            mul_b = MUL_B_W'($signed({1'b0, speed_per_count_ff}));
         end
         ST_P: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = MUL_B_W'($signed({1'b0, gain_p_ff}));
         end
         ST_I1: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = MUL_B_W'($signed({1'b0, gain_i_ff}));
         end
         ST_I2: begin
            mul_a = MUL_A_W'($signed(product[P_W-1:0]));
            mul_b = MUL_B_W'($signed({1'b0, tick_period_ff}));
         end
         ST_D1: begin
            mul_a = MUL_A_W'(diff);
            mul_b = MUL_B_W'($signed({1'b0, gain_d_ff}));
         end
         ST_D2: begin
            mul_a = $signed(product[MUL_A_W-1:0]);
            mul_b = MUL_B_W'($signed({1'b0, tick_rate_ff}));
         end
         default: ;
      endcase
   end

   // speed: round to nearest, then saturate
   always_comb begin
      spd_rnd = 57'($signed(product[55:0])) + 57'sd32768;
      spd_sh  = spd_rnd[56:16];
      if (spd_sh > 41'sd32767) begin
         spd_sat = 16'sh7fff;
      end else if (spd_sh < -41'sd32768) begin
         spd_sat = 16'sh8000;
      end else begin
         spd_sat = spd_sh[15:0];
      end
   end

   // derivative difference and rounded integral increment
   assign diff    = PERR_W'(err_ff) - cur_perr;
   assign inc_rnd = 50'($signed(product[48:0])) + 50'sd32768;

   // anti-windup gate: sign agreement and P + I under the sum limit
   assign psum    = INC_W'(p_ff) + INC_W'(cur_integ);
   assign sign_ok = (!err_ff[ERR_W-1] && !cur_integ[INTEG_W-1])
                 || ((err_ff[ERR_W-1] || err_ff == '0)
                     && (cur_integ[INTEG_W-1] || cur_integ == '0));

   // integral update and clamp
   always_comb begin
      ilim      = $signed({7'b0, integral_limit_ff, 20'b0});
      ival      = (INC_W + 1)'(cur_integ) + (grow_ff ? (INC_W + 1)'(inc_ff) : '0);
      integ_chk = (INC_W + 1)'(cur_integ);
      if (ival > ilim) begin
         integ_new = ilim[INTEG_W-1:0];
      end else if (ival < -ilim) begin
         integ_new = INTEG_W'(-ilim);
      end else begin
         integ_new = ival[INTEG_W-1:0];
      end
   end

   // output shaping: truncate, dead zone lift, saturate
   always_comb begin
      abs_sum = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      mag     = abs_sum[SUM_W-1:FRAC_BITS];
      mag_adj = mag;
      if (mag >= 25'(DEAD_ZONE) && mag < 25'(min_start_duty_ff)) begin
         mag_adj = 25'(min_start_duty_ff);
      end
      if (mag_adj > 25'(DUTY_MAX)) begin
         mag_adj = 25'(DUTY_MAX);
      end
   end

   // sequencer next state and register updates
   always_comb begin
      st_in        = st_ff;
      wheel_in     = wheel_ff;
      oor_in       = oor_ff;
      grow_in      = grow_ff;
      target_in    = target_ff;
      speed_in     = speed_ff;
      delta_in     = delta_ff;
      err_in       = err_ff;
      p_in         = p_ff;
      inc_in       = inc_ff;
      sum_in       = sum_ff;
      integ_in     = integ_ff;
      perr_in      = perr_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_wheel_in = rsp_wheel_ff;
      rsp_drive_in = rsp_drive_ff;
      rsp_duty_in  = rsp_duty_ff;
      rsp_speed_in = rsp_speed_ff;

      unique case (st_ff)
         ST_IDLE: begin
            if (req_fire) begin
               wheel_in  = req_if.wheel;
               target_in = req_if.target_speed;
               oor_in    = !in_range;
               delta_in  = req_if.encoder_count - $signed(last_ff[req_if.wheel]);
               if (in_range) begin
                  last_in[req_if.wheel] = req_if.encoder_count;
                  if (req_if.clear_integral) begin
                     integ_in[req_if.wheel] = '0;
                  end
                  st_in = ST_SPD;
               end else begin
                  st_in = ST_OUT;
               end
            end
         end
         ST_SPD: st_in = ST_ERR;
         ST_ERR: begin
            speed_in = spd_sat;
            err_in   = ERR_W'(target_ff) - ERR_W'(spd_sat);
            st_in    = ST_P;
         end
         ST_P:   st_in = ST_I1;
         ST_I1: begin
            p_in  = product[P_W-1:0];
            st_in = ST_I2;
         end
         ST_I2: begin
            grow_in = sign_ok && (psum < SUM_LIM_Q) && (psum > -SUM_LIM_Q);
            st_in   = ST_D1;
         end
         ST_D1: begin
            inc_in = inc_rnd[49:16];
            st_in  = ST_D2;
         end
         ST_D2: begin
            integ_in[wheel_ff] = integ_new;
            perr_in[wheel_ff]  = PERR_W'(err_ff);
            st_in              = ST_SUM;
         end
         ST_SUM: begin
            sum_in = SUM_W'(p_ff) + SUM_W'(cur_integ) + SUM_W'($signed(product[43:0]));
            st_in  = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_wheel_in = wheel_ff;
               if (oor_ff) begin
                  rsp_drive_in = DRIVE_OFF;
                  rsp_duty_in  = '0;
                  rsp_speed_in = '0;
               end else begin
                  rsp_speed_in = speed_ff;
                  if (mag >= 25'(DEAD_ZONE)) begin
                     rsp_drive_in = (sum_ff > 0) ? DRIVE_FORWARD : DRIVE_REVERSE;
                     rsp_duty_in  = mag_adj[7:0];
                  end else begin
                     rsp_drive_in = DRIVE_OFF;
                     rsp_duty_in  = '0;
                  end
               end
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WHEEL_COUNT; i++) begin
            integ_ff[i] <= '0;
            perr_ff[i]  <= '0;
            last_ff[i]  <= '0;
         end
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
         integ_ff     <= integ_in;
         perr_ff      <= perr_in;
         last_ff      <= last_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      wheel_ff     <= wheel_in;
      oor_ff       <= oor_in;
      grow_ff      <= grow_in;
      target_ff    <= target_in;
      speed_ff     <= speed_in;
      delta_ff     <= delta_in;
      err_ff       <= err_in;
      p_ff         <= p_in;
      inc_ff       <= inc_in;
      sum_ff       <= sum_in;
      rsp_wheel_ff <= rsp_wheel_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_duty_ff  <= rsp_duty_in;
      rsp_speed_ff <= rsp_speed_in;
   end

   // checks
   `WSP_ASSERT(a_busy_after_accept, req_fire |=> !req_if.ready, "request taken while busy")
   `WSP_ASSERT(a_integ_clamped, (st_ff == ST_SUM) |-> (integ_chk <= ilim && integ_chk >= -ilim), "integral outside limit")
   `WSP_ASSERT(a_off_zero_duty, (rsp_valid_ff && rsp_drive_ff == DRIVE_OFF) |-> (rsp_duty_ff == '0), "nonzero duty while off")
   `WSP_ASSERT(a_on_min_duty, (rsp_valid_ff && rsp_drive_ff != DRIVE_OFF) |-> (rsp_duty_ff >= 8'(DEAD_ZONE)), "drive on below dead zone")

endmodule

`default_nettype wire
